FILE: rtl/lcdws_pkg.sv
// Package for the character LCD write sequencer.
// Holds the item codes, the queue entry and control structs, the phase type,
// the register layout with reset values and the init sequence table.
package lcdws_pkg;

   localparam int WAIT_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_COMMAND = 3'd1,
      OP_DATA    = 3'd2,
      OP_CURSOR  = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_INIT    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_BYTE,
      KIND_CLEAR,
      KIND_INIT,
      KIND_IGNORE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_v;
      logic       rs;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_head_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_POWER,
      PH_PULSE,
      PH_SETTLE,
      PH_CLEARW
   } phase_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BUS_MODE         = 3'd0,
      CSR_ENABLE_PULSE     = 3'd1,
      CSR_COMMAND_WAIT     = 3'd2,
      CSR_DATA_WAIT_WIDE   = 3'd3,
      CSR_DATA_WAIT_NARROW = 3'd4,
      CSR_CLEAR_WAIT       = 3'd5,
      CSR_POWER_ON_WAIT    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        bus_mode;
      logic [7:0]  enable_pulse_us;
      logic [9:0]  command_wait_us;
      logic [9:0]  data_wait_wide_us;
      logic [9:0]  data_wait_narrow_us;
      logic [15:0] clear_wait_us;
      logic [15:0] power_on_wait_us;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      bus_mode:            1'b1,
      enable_pulse_us:     8'd1,
      command_wait_us:     10'd40,
      data_wait_wide_us:   10'd40,
      data_wait_narrow_us: 10'd100,
      clear_wait_us:       16'd5000,
      power_on_wait_us:    16'd20000
   };

   localparam logic [7:0] CURSOR_LINE1 = 8'h80;
   localparam logic [7:0] CURSOR_LINE2 = 8'hC0;
   localparam logic [7:0] CLEAR_CMD_BYTE = 8'h01;
   localparam logic [2:0] SEQ_LEN_WIDE   = 3'd4;
   localparam logic [2:0] SEQ_LEN_NARROW = 3'd6;

   function automatic logic [7:0] init_byte(input logic narrow, input logic [2:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (narrow) begin
         unique case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h01;
            default: b = 8'h00;
         endcase
      end else begin
         unique case (idx)
            3'd0:    b = 8'h38;
            3'd1:    b = 8'h0C;
            3'd2:    b = 8'h06;
            3'd3:    b = 8'h01;
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

FILE: rtl/lcdws_front.sv
// Front end of the LCD write sequencer: decodes an incoming item into a queue entry.
// Works out the cursor command byte and the RS level. Depends on lcdws_pkg.
module lcdws_front (
   input  logic [2:0]             req_op,
   input  logic [7:0]             req_byte_value,
   input  logic [1:0]             req_row,
   input  logic [5:0]             req_column,
   output lcdws_pkg::q_entry_type entry
);

   logic [7:0] cursor_base;

   assign cursor_base = (req_row == 2'd1) ? lcdws_pkg::CURSOR_LINE1 : lcdws_pkg::CURSOR_LINE2;

   always_comb begin
      entry.kind   = lcdws_pkg::KIND_IGNORE;
      entry.byte_v = req_byte_value;
      entry.rs     = 1'b0;
      unique case (req_op)
         lcdws_pkg::OP_TICK: begin
            entry.kind = lcdws_pkg::KIND_TICK;
         end
         lcdws_pkg::OP_COMMAND: begin
            entry.kind = lcdws_pkg::KIND_BYTE;
         end
         lcdws_pkg::OP_DATA: begin
            entry.kind = lcdws_pkg::KIND_BYTE;
            entry.rs   = 1'b1;
         end
         lcdws_pkg::OP_CURSOR: begin
            entry.kind   = lcdws_pkg::KIND_BYTE;
            entry.byte_v = cursor_base + {2'b00, req_column} - 8'd1;
         end
         lcdws_pkg::OP_CLEAR: begin
            entry.kind   = lcdws_pkg::KIND_CLEAR;
            entry.byte_v = lcdws_pkg::CLEAR_CMD_BYTE;
         end
         lcdws_pkg::OP_INIT: begin
            entry.kind = lcdws_pkg::KIND_INIT;
         end
         default: begin
            entry.kind = lcdws_pkg::KIND_IGNORE;
         end
      endcase
   end

endmodule

FILE: rtl/lcdws_queue.sv
// Short FIFO between the decode front end and the pin sequencer.
// DEPTH must be a power of two of at least two. Depends on lcdws_pkg.
module lcdws_queue #(
   parameter int DEPTH = lcdws_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lcdws_pkg::q_entry_type push_entry,
   output logic                   not_full,
   input  logic                   pop,
   output lcdws_pkg::q_head_type  head
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   lcdws_pkg::q_entry_type mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign not_full   = (count_ff != CNT_BITS'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/lcdws_back.sv
// LCD write sequencer back end: if unstalled, runs one queue entry per cycle against the
// pin state, wait counter and init sequencer, and holds the result. Depends on lcdws_pkg.
module lcdws_back #(
   parameter int WAIT_BITS = lcdws_pkg::WAIT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lcdws_pkg::cfg_type    cfg,
   input  lcdws_pkg::q_head_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_data_pins,
   output logic                  rsp_reg_select,
   output logic                  rsp_enable_pin,
   output logic                  rsp_read_write_pin,
   output logic                  rsp_backlight_pin,
   output logic                  rsp_busy_res,
   output logic                  rsp_accepted
);

   localparam logic [32:0] WAIT_MAX = (33'd1 << WAIT_BITS) - 33'd1;

   function automatic logic [WAIT_BITS-1:0] load_wait(input logic [15:0] d);
      logic [32:0] wide;
      wide = {17'd0, d};
      if (wide > WAIT_MAX) begin
         wide = WAIT_MAX;
      end
      return wide[WAIT_BITS-1:0];
   endfunction

   lcdws_pkg::phase_type phase_ff, phase_in;
   logic [WAIT_BITS-1:0] wait_ff, wait_in;
   logic [7:0] pend_ff, pend_in;
   logic       second_ff, second_in;
   logic [2:0] step_ff, step_in;
   logic       clrp_ff, clrp_in;
   logic [7:0] data_ff, data_in;
   logic       rs_ff, rs_in;
   logic       en_ff, en_in;
   logic       rw_ff, rw_in;
   logic       bl_ff, bl_in;
   logic       acc_ff, acc_in;
   logic       valid_ff, valid_in;

   logic       start_req;
   logic [7:0] start_byte;
   logic       start_rs;
   logic       init_send;
   logic       finish;
   logic [2:0] seq_len;
   logic [3:0] step_inc;

   assign seq_len = cfg.bus_mode ? lcdws_pkg::SEQ_LEN_NARROW : lcdws_pkg::SEQ_LEN_WIDE;
   assign pop     = head.valid && (!valid_ff || rsp_ready);

   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      pend_in    = pend_ff;
      second_in  = second_ff;
      step_in    = step_ff;
      clrp_in    = clrp_ff;
      data_in    = data_ff;
      rs_in      = rs_ff;
      en_in      = en_ff;
      rw_in      = rw_ff;
      bl_in      = bl_ff;
      acc_in     = 1'b0;
      start_req  = 1'b0;
      start_byte = head.entry.byte_v;
      start_rs   = head.entry.rs;
      init_send  = 1'b0;
      finish     = 1'b0;
      step_inc   = 4'd0;

      if (head.entry.kind == lcdws_pkg::KIND_TICK) begin
         if (phase_ff != lcdws_pkg::PH_IDLE) begin
            if (wait_ff <= WAIT_BITS'(1)) begin
               wait_in = '0;
               unique case (phase_ff)
                  lcdws_pkg::PH_POWER: begin
                     step_in   = 3'd0;
                     init_send = 1'b1;
                  end
                  lcdws_pkg::PH_PULSE: begin
                     en_in    = 1'b0;
                     phase_in = lcdws_pkg::PH_SETTLE;
                     if (!rs_ff) begin
                        wait_in = load_wait({6'd0, cfg.command_wait_us});
                     end else if (cfg.bus_mode) begin
                        wait_in = load_wait({6'd0, cfg.data_wait_narrow_us});
                     end else begin
                        wait_in = load_wait({6'd0, cfg.data_wait_wide_us});
                     end
                  end
                  lcdws_pkg::PH_SETTLE: begin
                     if (cfg.bus_mode && !second_ff) begin
                        second_in = 1'b1;
                        data_in   = {pend_ff[3:0], 4'h0};
                        en_in     = 1'b1;
                        phase_in  = lcdws_pkg::PH_PULSE;
                        wait_in   = load_wait({8'd0, cfg.enable_pulse_us});
                     end else begin
                        second_in = 1'b0;
                        if (clrp_ff) begin
                           clrp_in  = 1'b0;
                           phase_in = lcdws_pkg::PH_CLEARW;
                           wait_in  = load_wait(cfg.clear_wait_us);
                        end else begin
                           finish = 1'b1;
                        end
                     end
                  end
                  lcdws_pkg::PH_CLEARW: begin
                     finish = 1'b1;
                  end
                  default: begin
                     phase_in = lcdws_pkg::PH_IDLE;
                  end
               endcase
            end else begin
               wait_in = wait_ff - WAIT_BITS'(1);
            end
         end
      end else if (head.entry.kind != lcdws_pkg::KIND_IGNORE
                   && phase_ff == lcdws_pkg::PH_IDLE) begin
         acc_in  = 1'b1;
         step_in = 3'd0;
         clrp_in = 1'b0;
         unique case (head.entry.kind)
            lcdws_pkg::KIND_BYTE: begin
               start_req = 1'b1;
            end
            lcdws_pkg::KIND_CLEAR: begin
               clrp_in   = 1'b1;
               start_req = 1'b1;
            end
            lcdws_pkg::KIND_INIT: begin
               rw_in    = 1'b0;
               bl_in    = 1'b1;
               phase_in = lcdws_pkg::PH_POWER;
               wait_in  = load_wait(cfg.power_on_wait_us);
            end
            default: begin
               acc_in = 1'b1;
            end
         endcase
      end

      if (finish) begin
         if (step_in != 3'd0 && step_in < seq_len) begin
            init_send = 1'b1;
         end else begin
            step_in  = 3'd0;
            phase_in = lcdws_pkg::PH_IDLE;
            wait_in  = '0;
         end
      end

      if (init_send) begin
         step_inc   = {1'b0, step_in} + 4'd1;
         clrp_in    = (step_inc == {1'b0, seq_len});
         start_byte = lcdws_pkg::init_byte(cfg.bus_mode, step_in);
         start_rs   = 1'b0;
         step_in    = step_inc[2:0];
         start_req  = 1'b1;
      end

      if (start_req) begin
         pend_in   = start_byte;
         second_in = 1'b0;
         data_in   = start_byte;
         rs_in     = start_rs;
         en_in     = 1'b1;
         phase_in  = lcdws_pkg::PH_PULSE;
         wait_in   = load_wait({8'd0, cfg.enable_pulse_us});
      end
   end

   always_comb begin
      valid_in           = pop || (valid_ff && !rsp_ready);
      rsp_valid          = valid_ff;
      rsp_data_pins      = data_ff;
      rsp_reg_select     = rs_ff;
      rsp_enable_pin     = en_ff;
      rsp_read_write_pin = rw_ff;
      rsp_backlight_pin  = bl_ff;
      rsp_busy_res       = (phase_ff != lcdws_pkg::PH_IDLE);
      rsp_accepted       = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lcdws_pkg::PH_IDLE;
         wait_ff   <= '0;
         pend_ff   <= '0;
         second_ff <= 1'b0;
         step_ff   <= '0;
         clrp_ff   <= 1'b0;
         data_ff   <= '0;
         rs_ff     <= 1'b0;
         en_ff     <= 1'b0;
         rw_ff     <= 1'b0;
         bl_ff     <= 1'b0;
         acc_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            phase_ff  <= phase_in;
            wait_ff   <= wait_in;
            pend_ff   <= pend_in;
            second_ff <= second_in;
            step_ff   <= step_in;
            clrp_ff   <= clrp_in;
            data_ff   <= data_in;
            rs_ff     <= rs_in;
            en_ff     <= en_in;
            rw_ff     <= rw_in;
            bl_ff     <= bl_in;
            acc_ff    <= acc_in;
         end
      end
   end

endmodule

FILE: rtl/char_lcd_write_sequencer.sv
// Top level of the character LCD write sequencer: register file, decode front end,
// item queue and pin sequencer. Depends on lcdws_pkg, lcdws_front, lcdws_queue, lcdws_back.
// The block takes one item per clock while the queue has room and returns one result
// per item; an accepted item is written into the queue, popped from it by the pin
// sequencer and held in its result register, which offers it. The rate is set by the pin
// sequencer, which applies one item per cycle to its state while its result register is
// free or being taken, and a short queue lets the input side keep accepting while the
// output waits; the queue and result register hold up to three items before input stalls.
module char_lcd_write_sequencer #(
   parameter int WAIT_BITS   = lcdws_pkg::WAIT_BITS_DEF,
   parameter int QUEUE_DEPTH = lcdws_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [2:0]                           req_op,
   input  logic [7:0]                           req_byte_value,
   input  logic [1:0]                           req_row,
   input  logic [5:0]                           req_column,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_data_pins,
   output logic                                 rsp_reg_select,
   output logic                                 rsp_enable_pin,
   output logic                                 rsp_read_write_pin,
   output logic                                 rsp_backlight_pin,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_accepted,
   input  logic                                 csr_wr_en,
   input  logic [lcdws_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lcdws_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   lcdws_pkg::cfg_type     cfg_ff, cfg_in;
   lcdws_pkg::q_entry_type entry;
   lcdws_pkg::q_head_type  head;
   logic                   pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lcdws_pkg::CSR_BUS_MODE:         cfg_in.bus_mode            = csr_wdata[0];
            lcdws_pkg::CSR_ENABLE_PULSE:     cfg_in.enable_pulse_us     = csr_wdata[7:0];
            lcdws_pkg::CSR_COMMAND_WAIT:     cfg_in.command_wait_us     = csr_wdata[9:0];
            lcdws_pkg::CSR_DATA_WAIT_WIDE:   cfg_in.data_wait_wide_us   = csr_wdata[9:0];
            lcdws_pkg::CSR_DATA_WAIT_NARROW: cfg_in.data_wait_narrow_us = csr_wdata[9:0];
            lcdws_pkg::CSR_CLEAR_WAIT:       cfg_in.clear_wait_us       = csr_wdata[15:0];
            lcdws_pkg::CSR_POWER_ON_WAIT:    cfg_in.power_on_wait_us    = csr_wdata[15:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lcdws_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdws_front u_front (
      .req_op         (req_op),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .entry          (entry)
   );

   lcdws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && req_ready),
      .push_entry (entry),
      .not_full   (req_ready),
      .pop        (pop),
      .head       (head)
   );

   lcdws_back #(
      .WAIT_BITS (WAIT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_pins      (rsp_data_pins),
      .rsp_reg_select     (rsp_reg_select),
      .rsp_enable_pin     (rsp_enable_pin),
      .rsp_read_write_pin (rsp_read_write_pin),
      .rsp_backlight_pin  (rsp_backlight_pin),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_accepted       (rsp_accepted)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_busy_res)
      else $error("accepted request left the sequencer idle");

   a_enable_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable_pin |-> rsp_busy_res)
      else $error("enable pin high while sequencer idle");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid && (!rsp_valid || rsp_ready))
      else $error("queue popped without room for the result");

endmodule
